[hw/rtl/ilse_pkg.sv]
`timescale 1ns / 1ps

package ilse_pkg;

	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_ELEMENT_WIDTH = 32;

	localparam int FUNC_W = 3;
	localparam int IDX_W  = 5;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 5;
	localparam int STAT_W = 2;

	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	// read address select
	localparam logic [1:0] RA_IDX    = 2'd0;
	localparam logic [1:0] RA_PTR_DN = 2'd1;
	localparam logic [1:0] RA_PTR_UP = 2'd2;

	// write address select
	localparam logic [1:0] WA_COUNT = 2'd0;
	localparam logic [1:0] WA_IDX   = 2'd1;
	localparam logic [1:0] WA_PTR   = 2'd2;

	// write data select
	localparam logic WD_VAL   = 1'b0;
	localparam logic WD_RDATA = 1'b1;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [1:0]        rd_sel;
		logic              wr_en;
		logic [1:0]        wa_sel;
		logic              wd_sel;
		logic              ptr_ld_cnt;
		logic              ptr_ld_idx;
		logic              ptr_inc;
		logic              ptr_dec;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              cap;
		logic              finish;
		logic [STAT_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              bad_low;
		logic              bad_ins;
		logic              full;
		logic              ins_more;
		logic              pop_more;
	} stat_t;

endpackage

[hw/rtl/indexed_list_shift_engine_top.sv]
// Append, write, length and refused items end in decode; read waits for the registered
// storage read; insert moves each entry from index to the end up by one, top first; pop
// captures the entry at index, then pulls each later entry down. Each moved entry is read,
// then written back. A new item is taken while done is high, but none while busy.
// Reset (arst_n low) empties the list at once; stored words stay undefined until written.
// Done is high for one cycle only: the receiver cannot stall. value_out and status hold.
`timescale 1ns / 1ps

module indexed_list_shift_engine_top #(
	parameter int CAPACITY      = ilse_pkg::DEF_CAPACITY,
	parameter int ELEMENT_WIDTH = ilse_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ilse_pkg::FUNC_W-1:0] func,
	input  logic [ilse_pkg::IDX_W-1:0]  index,
	input  logic [ilse_pkg::VAL_W-1:0]  value_in,
	output logic                        done,
	output logic [ilse_pkg::VAL_W-1:0]  value_out,
	output logic [ilse_pkg::LEN_W-1:0]  length,
	output logic [ilse_pkg::STAT_W-1:0] status
);

	import ilse_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ilse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ilse_dp #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.index     (index),
		.value_in  (value_in),
		.cmd       (cmd),
		.stat      (stat),
		.value_out (value_out),
		.length    (length),
		.status    (status)
	);

endmodule

[hw/rtl/ilse_ram.sv]
`timescale 1ns / 1ps

module ilse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ilse_dp.sv]
`timescale 1ns / 1ps

module ilse_dp #(
	parameter int CAPACITY      = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ilse_pkg::FUNC_W-1:0]   func,
	input  logic [ilse_pkg::IDX_W-1:0]    index,
	input  logic [ilse_pkg::VAL_W-1:0]    value_in,
	input  ilse_pkg::cmd_t                cmd,
	output ilse_pkg::stat_t               stat,
	output logic [ilse_pkg::VAL_W-1:0]    value_out,
	output logic [ilse_pkg::LEN_W-1:0]    length,
	output logic [ilse_pkg::STAT_W-1:0]   status
);

	import ilse_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;

	logic [FUNC_W-1:0]        func_q;
	logic [IDX_W-1:0]         idx_q;
	logic [ELEMENT_WIDTH-1:0] val_q;
	logic [ELEMENT_WIDTH-1:0] res_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            ptr_q;
	logic [VAL_W-1:0]         value_out_q;
	logic [STAT_W-1:0]        status_q;

	logic [ELEMENT_WIDTH+VAL_W-1:0] vin_wide;
	logic [ELEMENT_WIDTH+VAL_W-1:0] vout_wide;
	logic [ELEMENT_WIDTH-1:0]       out_src;
	logic [CW+LEN_W-1:0]            len_wide;
	logic [CMPW-1:0]                idx_ext;
	logic [CMPW-1:0]                cnt_ext;
	logic [CMPW-1:0]                ptr_ext;
	logic [CMPW-1:0]                ptr_up_ext;
	logic [CW-1:0]                  idx_cw;
	logic [CW-1:0]                  ptr_dn;
	logic [CW-1:0]                  ptr_up;
	logic [AW-1:0]                  raddr;
	logic [AW-1:0]                  waddr;
	logic [ELEMENT_WIDTH-1:0]       wdata;
	logic [ELEMENT_WIDTH-1:0]       rdata;

	assign vin_wide   = {{ELEMENT_WIDTH{1'b0}}, value_in};
	assign out_src    = cmd.cap ? rdata : res_q;
	assign vout_wide  = {{VAL_W{1'b0}}, out_src};
	assign len_wide   = {{LEN_W{1'b0}}, count_q};
	assign idx_ext    = {{(CMPW-IDX_W){1'b0}}, idx_q};
	assign cnt_ext    = {{(CMPW-CW){1'b0}}, count_q};
	assign ptr_ext    = {{(CMPW-CW){1'b0}}, ptr_q};
	assign ptr_up_ext = ptr_ext + CMPW'(1);
	assign idx_cw     = idx_ext[CW-1:0];
	assign ptr_dn     = ptr_q - CW'(1);
	assign ptr_up     = ptr_up_ext[CW-1:0];

	assign stat.func     = func_q;
	assign stat.bad_low  = (idx_ext >= cnt_ext);
	assign stat.bad_ins  = (idx_ext > cnt_ext);
	assign stat.full     = (cnt_ext == CMPW'(CAPACITY));
	assign stat.ins_more = (ptr_ext > idx_ext);
	assign stat.pop_more = (ptr_up_ext < cnt_ext);

	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:    raddr = idx_cw[AW-1:0];
			RA_PTR_DN: raddr = ptr_dn[AW-1:0];
			RA_PTR_UP: raddr = ptr_up[AW-1:0];
			default:   raddr = idx_cw[AW-1:0];
		endcase
	end

	always_comb begin
		case (cmd.wa_sel)
			WA_COUNT: waddr = count_q[AW-1:0];
			WA_IDX:   waddr = idx_cw[AW-1:0];
			WA_PTR:   waddr = ptr_q[AW-1:0];
			default:  waddr = count_q[AW-1:0];
		endcase
	end

	assign wdata = (cmd.wd_sel == WD_RDATA) ? rdata : val_q;

	ilse_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q  <= index;
			val_q  <= vin_wide[ELEMENT_WIDTH-1:0];
		end
		// clear on load so refused requests return zero
		if (cmd.load) begin
			res_q <= '0;
		end else if (cmd.cap) begin
			res_q <= rdata;
		end
		if (cmd.finish) begin
			value_out_q <= vout_wide[VAL_W-1:0];
			status_q    <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ptr_ld_cnt) begin
				ptr_q <= count_q;
			end else if (cmd.ptr_ld_idx) begin
				ptr_q <= idx_cw;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_up;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_dn;
			end
		end
	end

	assign value_out = value_out_q;
	assign length    = len_wide[LEN_W-1:0];
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= CMPW'(CAPACITY))
		else $error("element count exceeds capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(count_q))
		else $error("element count changed outside request completion");

	a_cap_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> $past(cmd.rd_en))
		else $error("result captured without a preceding storage read");
`endif

endmodule

[hw/rtl/ilse_ctrl.sv]
`timescale 1ns / 1ps

module ilse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ilse_pkg::stat_t stat,
	output ilse_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	import ilse_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_RD_WAIT = 3'd2;
	localparam logic [2:0] S_POP_CAP = 3'd3;
	localparam logic [2:0] S_POP_RD  = 3'd4;
	localparam logic [2:0] S_POP_WR  = 3'd5;
	localparam logic [2:0] S_INS_RD  = 3'd6;
	localparam logic [2:0] S_INS_WR  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.func)
					FN_APPEND: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.status  = ST_OK;
							cmd.wr_en   = 1'b1;
							cmd.wa_sel  = WA_COUNT;
							cmd.wd_sel  = WD_VAL;
							cmd.cnt_inc = 1'b1;
						end
					end
					FN_INSERT: begin
						// index check first, then capacity
						if (stat.bad_ins) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BOUNDS;
							state_d    = S_IDLE;
						end else if (stat.full) begin
							cmd.finish = 1'b1;
							cmd.status = ST_FULL;
							state_d    = S_IDLE;
						end else begin
							cmd.ptr_ld_cnt = 1'b1;
							state_d        = S_INS_RD;
						end
					end
					FN_POP: begin
						if (stat.bad_low) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BOUNDS;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_en      = 1'b1;
							cmd.rd_sel     = RA_IDX;
							cmd.ptr_ld_idx = 1'b1;
							state_d        = S_POP_CAP;
						end
					end
					FN_READ: begin
						if (stat.bad_low) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BOUNDS;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_IDX;
							state_d    = S_RD_WAIT;
						end
					end
					FN_WRITE: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.bad_low) begin
							cmd.status = ST_BOUNDS;
						end else begin
							cmd.status = ST_OK;
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = WA_IDX;
							cmd.wd_sel = WD_VAL;
						end
					end
					default: begin
						// length request and unused codes
						cmd.finish = 1'b1;
						cmd.status = ST_OK;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_RD_WAIT: begin
				cmd.cap    = 1'b1;
				cmd.finish = 1'b1;
				cmd.status = ST_OK;
				state_d    = S_IDLE;
			end
			S_POP_CAP: begin
				cmd.cap = 1'b1;
				state_d = S_POP_RD;
			end
			S_POP_RD: begin
				// pull the next entry down, or close the gap at the end
				if (stat.pop_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR_UP;
					state_d    = S_POP_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.finish  = 1'b1;
					cmd.status  = ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_POP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = WA_PTR;
				cmd.wd_sel  = WD_RDATA;
				cmd.ptr_inc = 1'b1;
				state_d     = S_POP_RD;
			end
			S_INS_RD: begin
				// move entries up from the top until the slot is free
				if (stat.ins_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR_DN;
					state_d    = S_INS_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wa_sel  = WA_IDX;
					cmd.wd_sel  = WD_VAL;
					cmd.cnt_inc = 1'b1;
					cmd.finish  = 1'b1;
					cmd.status  = ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = WA_PTR;
				cmd.wd_sel  = WD_RDATA;
				cmd.ptr_dec = 1'b1;
				state_d     = S_INS_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while a request is still in progress");

	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE) && !done_q)
		else $error("accepted item did not enter decode");
`endif

endmodule
